// ===== design/prioritized_delimiter_splitter_top_macros.svh =====
// Assertion macros for the prioritized delimiter splitter.
// Used by the top level only; no other dependencies.
`ifndef PRIORITIZED_DELIMITER_SPLITTER_TOP_MACROS_SVH
`define PRIORITIZED_DELIMITER_SPLITTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define PDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("pds: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define PDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("pds: next-cycle check failed");

`endif

// ===== design/pds_pkg.sv =====
// Shared types, codes and delimiter tables for the delimiter splitter.
// No dependencies; used by pds_cfg, pds_match, pds_window, the top level and the bench.
package pds_pkg;

  localparam int unsigned MAX_DELIM_BYTES = 8;
  localparam int unsigned MAX_DELIMS      = 4;
  // Number of delimiter compare slots (built-in lists and custom registers)
  localparam int unsigned NUM_SLOTS       = 4;
  localparam int unsigned CUSTOM_CAP      = (MAX_DELIMS < NUM_SLOTS) ? MAX_DELIMS : NUM_SLOTS;
  localparam int unsigned CFG_DATA_W      = 64;
  localparam int unsigned CFG_INDEX_W     = 3;
  localparam int unsigned FILL_MAX_W      = 4;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef enum logic [1:0] {
    MODE_CUSTOM = 2'd0,
    MODE_LINE   = 2'd1,
    MODE_DOUBLE = 2'd2
  } split_mode_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SPLIT_MODE = 3'd0,
    CFG_DELIM_CNT  = 3'd1,
    CFG_DELIM_LENS = 3'd2,
    CFG_DELIM_A    = 3'd3,
    CFG_DELIM_B    = 3'd4,
    CFG_DELIM_C    = 3'd5,
    CFG_DELIM_D    = 3'd6
  } cfg_index_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_END  = 2'd1,
    KIND_NULL = 2'd2
  } kind_e;

  // Built-in delimiter lists, slot 0 has highest priority
  localparam logic [3:0] LINE_LEN [NUM_SLOTS] = '{4'd2, 4'd1, 4'd2, 4'd1};
  localparam logic [63:0] LINE_VAL [NUM_SLOTS] = '{
    64'({CHAR_CR, CHAR_LF}), 64'(CHAR_LF), 64'({CHAR_LF, CHAR_CR}), 64'(CHAR_CR)};
  localparam logic [3:0] DBL_LEN [NUM_SLOTS] = '{4'd2, 4'd4, 4'd2, 4'd4};
  localparam logic [63:0] DBL_VAL [NUM_SLOTS] = '{
    64'({CHAR_LF, CHAR_LF}),
    64'({CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF}),
    64'({CHAR_CR, CHAR_CR}),
    64'({CHAR_LF, CHAR_CR, CHAR_LF, CHAR_CR})};

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_present;
    logic       end_of_string;
  } pds_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    kind_e      kind;
    logic       final_item;
  } pds_result_t;

  // Active delimiter set as seen by the matcher
  typedef struct packed {
    logic [NUM_SLOTS-1:0][3:0]  len;
    logic [NUM_SLOTS-1:0][63:0] val;
    logic [2:0]                 count;
  } pds_delims_t;

  typedef struct packed {
    logic                  draining;
    logic [FILL_MAX_W-1:0] fill;
  } pds_status_t;

endpackage

// ===== design/pds_if.sv =====
// Valid/ready stream interfaces for the delimiter splitter requests and results.
// No dependencies.
interface pds_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       byte_present;
  logic       end_of_string;

  modport source (output valid, in_byte, byte_present, end_of_string, input ready);
  modport sink   (input valid, in_byte, byte_present, end_of_string, output ready);
endinterface

interface pds_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       final_item;

  modport source (output valid, out_byte, kind, final_item, input ready);
  modport sink   (input valid, out_byte, kind, final_item, output ready);
endinterface

// ===== design/prioritized_delimiter_splitter_top.sv =====
// Prioritized delimiter splitter: input register, window resolve, result register.
// Throughput: one byte per cycle while the result slot is free and no drain runs; an
// end-of-string request then drains the window, one result per cycle while the result
// slot is free, set by the single resolve unit that decides one window head per cycle.
// Reset (rst_ni, async low) empties the window and registers; no clearing pass.
`include "prioritized_delimiter_splitter_top_macros.svh"

module prioritized_delimiter_splitter_top #(
  parameter int unsigned MaxDelimBytes = pds_pkg::MAX_DELIM_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [pds_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [pds_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  pds_in_if.sink                          in_if,
  pds_out_if.source                       out_if
);

  pds_pkg::pds_delims_t delims;
  pds_pkg::pds_item_t   in_item_q;
  pds_pkg::pds_result_t result, out_res_q;
  pds_pkg::pds_status_t status;
  logic                 in_valid_q, out_valid_q;
  logic                 take, emit, slot_free;

  pds_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .delims_o    (delims)
  );

  // Input register
  assign in_if.ready = !in_valid_q || take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.valid && in_if.ready) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      in_item_q.in_byte       <= in_if.in_byte;
      in_item_q.byte_present  <= in_if.byte_present;
      in_item_q.end_of_string <= in_if.end_of_string;
    end
  end

  pds_window #(.MaxBytes(MaxDelimBytes)) u_window (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (in_valid_q),
    .item_i       (in_item_q),
    .delims_i     (delims),
    .slot_free_i  (slot_free),
    .take_o       (take),
    .emit_o       (emit),
    .result_o     (result),
    .status_o     (status)
  );

  // Result register
  assign slot_free = !out_valid_q || out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) out_res_q <= result;
  end

  assign out_if.valid      = out_valid_q;
  assign out_if.out_byte   = out_res_q.out_byte;
  assign out_if.kind       = out_res_q.kind;
  assign out_if.final_item = out_res_q.final_item;

  // Checks
  `PDS_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, emit, slot_free)
  `PDS_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, status.fill <= MaxDelimBytes)
  `PDS_ASSERT_IMP(a_no_take_in_drain, clk_i, rst_ni, status.draining, !take)
  `PDS_ASSERT_NEXT(a_final_clears, clk_i, rst_ni, emit && result.final_item,
                   !status.draining && status.fill == '0)

endmodule

// ===== design/pds_cfg.sv =====
// Configuration registers and selection of the active delimiter list.
// Depends on pds_pkg.
module pds_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [pds_pkg::CFG_INDEX_W-1:0]      cfg_index_i,
  input  logic [pds_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  output pds_pkg::pds_delims_t                 delims_o
);

  logic [1:0]  mode_q;
  logic [2:0]  count_q;
  logic [15:0] lens_q;
  logic [63:0] dval_q [pds_pkg::NUM_SLOTS];

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= pds_pkg::MODE_LINE;
      count_q <= 3'd1;
      lens_q  <= '0;
      for (int i = 0; i < pds_pkg::NUM_SLOTS; i++) dval_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pds_pkg::CFG_SPLIT_MODE: mode_q    <= cfg_data_i[1:0];
        pds_pkg::CFG_DELIM_CNT:  count_q   <= cfg_data_i[2:0];
        pds_pkg::CFG_DELIM_LENS: lens_q    <= cfg_data_i[15:0];
        pds_pkg::CFG_DELIM_A:    dval_q[0] <= cfg_data_i;
        pds_pkg::CFG_DELIM_B:    dval_q[1] <= cfg_data_i;
        pds_pkg::CFG_DELIM_C:    dval_q[2] <= cfg_data_i;
        pds_pkg::CFG_DELIM_D:    dval_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pick built-in or custom list; mode 3 falls back to custom
  always_comb begin
    delims_o = '0;
    unique case (mode_q)
      pds_pkg::MODE_LINE: begin
        delims_o.count = 3'(pds_pkg::NUM_SLOTS);
        for (int i = 0; i < pds_pkg::NUM_SLOTS; i++) begin
          delims_o.len[i] = pds_pkg::LINE_LEN[i];
          delims_o.val[i] = pds_pkg::LINE_VAL[i];
        end
      end
      pds_pkg::MODE_DOUBLE: begin
        delims_o.count = 3'(pds_pkg::NUM_SLOTS);
        for (int i = 0; i < pds_pkg::NUM_SLOTS; i++) begin
          delims_o.len[i] = pds_pkg::DBL_LEN[i];
          delims_o.val[i] = pds_pkg::DBL_VAL[i];
        end
      end
      default: begin
        delims_o.count = (count_q > 3'(pds_pkg::CUSTOM_CAP)) ?
                         3'(pds_pkg::CUSTOM_CAP) : count_q;
        for (int i = 0; i < pds_pkg::NUM_SLOTS; i++) begin
          delims_o.len[i] = lens_q[4*i +: 4];
          delims_o.val[i] = dval_q[i];
        end
      end
    endcase
  end

endmodule

// ===== design/pds_match.sv =====
// Parallel compare of all delimiter slots against the lookahead window,
// with priority pick of the first hit. Depends on pds_pkg.
module pds_match #(
  parameter int unsigned MaxBytes = pds_pkg::MAX_DELIM_BYTES,
  localparam int unsigned FillW   = $clog2(MaxBytes + 1)
) (
  input  logic [7:0]           win_i [MaxBytes],
  input  logic [FillW-1:0]     fill_i,
  input  pds_pkg::pds_delims_t delims_i,
  output logic                 hit_o,
  output logic [FillW-1:0]     len_o
);

  logic [pds_pkg::NUM_SLOTS-1:0] slot_hit;

  // Per-slot match: enabled, fully inside the window, all bytes equal
  always_comb begin
    for (int i = 0; i < pds_pkg::NUM_SLOTS; i++) begin
      slot_hit[i] = (3'(i) < delims_i.count) &&
                    (delims_i.len[i] != 4'd0) &&
                    (delims_i.len[i] <= 4'(MaxBytes)) &&
                    ({1'b0, delims_i.len[i]} <= 5'(fill_i));
      for (int j = 0; j < MaxBytes; j++) begin
        if ((4'(j) < delims_i.len[i]) && (delims_i.val[i][8*j +: 8] != win_i[j]))
          slot_hit[i] = 1'b0;
      end
    end
  end

  // Lowest slot wins
  always_comb begin
    hit_o = 1'b0;
    len_o = '0;
    for (int i = pds_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (slot_hit[i]) begin
        hit_o = 1'b1;
        len_o = FillW'(delims_i.len[i]);
      end
    end
  end

endmodule

// ===== design/pds_window.sv =====
// Lookahead window, item state and per-cycle resolve of the window head.
// Depends on pds_pkg and pds_match.
module pds_window #(
  parameter int unsigned MaxBytes = pds_pkg::MAX_DELIM_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  pds_pkg::pds_item_t   item_i,
  input  pds_pkg::pds_delims_t delims_i,
  input  logic                 slot_free_i,
  output logic                 take_o,
  output logic                 emit_o,
  output pds_pkg::pds_result_t result_o,
  output pds_pkg::pds_status_t status_o
);

  localparam int unsigned FillW = $clog2(MaxBytes + 1);
  localparam logic [FillW-1:0] FullFill = FillW'(MaxBytes);

  logic [7:0]       win_q [MaxBytes];
  logic [7:0]       win_d [MaxBytes];
  logic [7:0]       eff_win [MaxBytes];
  logic [7:0]       shift_win [MaxBytes];
  logic [FillW-1:0] fill_q, fill_d, eff_fill, drop, match_len;
  logic             has_q, has_d, drain_q, drain_d;
  logic             push, work, end_mode, resolve, close_str, match_hit;

  // Take a request when not draining and the result slot is free
  assign take_o = item_valid_i && !drain_q && slot_free_i;
  assign push   = take_o && item_i.byte_present && (fill_q < FullFill);

  // Window as it stands after the incoming byte
  always_comb begin
    for (int j = 0; j < MaxBytes; j++)
      eff_win[j] = (push && fill_q == FillW'(j)) ? item_i.in_byte : win_q[j];
    eff_fill = fill_q + FillW'(push);
  end

  pds_match #(.MaxBytes(MaxBytes)) u_match (
    .win_i    (eff_win),
    .fill_i   (eff_fill),
    .delims_i (delims_i),
    .hit_o    (match_hit),
    .len_o    (match_len)
  );

  assign work      = slot_free_i && (drain_q || item_valid_i);
  assign end_mode  = drain_q || (take_o && item_i.end_of_string);
  assign resolve   = work && (end_mode ? (eff_fill != '0) : (eff_fill == FullFill));
  assign close_str = work && end_mode && (eff_fill == '0);
  assign drop      = match_hit ? match_len : FillW'(1);

  // Drop the head bytes: delimiter length on a hit, else one
  always_comb begin
    for (int j = 0; j < MaxBytes; j++) begin
      shift_win[j] = eff_win[j];
      for (int d = 1; j + d < MaxBytes; d++) begin
        if (drop == FillW'(d)) shift_win[j] = eff_win[j + d];
      end
    end
  end

  // Next state and result
  always_comb begin
    win_d    = win_q;
    fill_d   = fill_q;
    has_d    = has_q;
    drain_d  = drain_q;
    emit_o   = 1'b0;
    result_o = '0;
    if (resolve) begin
      emit_o  = 1'b1;
      win_d   = shift_win;
      fill_d  = eff_fill - drop;
      drain_d = end_mode;
      if (match_hit) begin
        result_o.kind = has_q ? pds_pkg::KIND_END : pds_pkg::KIND_NULL;
        has_d         = 1'b0;
      end else begin
        result_o.out_byte = eff_win[0];
        result_o.kind     = pds_pkg::KIND_BYTE;
        has_d             = 1'b1;
      end
    end else if (close_str) begin
      emit_o              = 1'b1;
      result_o.kind       = has_q ? pds_pkg::KIND_END : pds_pkg::KIND_NULL;
      result_o.final_item = 1'b1;
      fill_d              = '0;
      has_d               = 1'b0;
      drain_d             = 1'b0;
    end else if (take_o) begin
      win_d  = eff_win;
      fill_d = eff_fill;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      has_q   <= 1'b0;
      drain_q <= 1'b0;
    end else begin
      fill_q  <= fill_d;
      has_q   <= has_d;
      drain_q <= drain_d;
    end
  end

  // Window bytes above the fill level are never read
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  assign status_o.draining = drain_q;
  assign status_o.fill     = pds_pkg::FILL_MAX_W'(fill_q);

endmodule

// ===== test/tb_prioritized_delimiter_splitter_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the prioritized delimiter splitter: directed strings, then random
// text per delimiter setting. Depends on pds_pkg, pds_if and the top level.
module tb_prioritized_delimiter_splitter_top;
  import pds_pkg::*;

  localparam int unsigned SETTLE_CYCLES   = 12;
  localparam int unsigned SETTING_ITEMS   = 36;
  localparam logic [1:0]  MODE_ALIAS_CUST = 2'd3;

  // Tracks the split state and holds the pieces still to come out
  class split_tracker;
    logic [1:0]  mode;
    logic [2:0]  count;
    logic [15:0] lens;
    logic [63:0] custom [NUM_SLOTS];
    logic [7:0]  window [MAX_DELIM_BYTES];
    int unsigned fill;
    bit          has_bytes;
    int unsigned errors;
    pds_result_t expected_pieces [$];

    function new();
      mode      = MODE_LINE;
      count     = 3'd1;
      lens      = '0;
      fill      = 0;
      has_bytes = 0;
      errors    = 0;
      foreach (custom[i]) custom[i] = '0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void write_reg(cfg_index_e idx, logic [63:0] data);
      case (idx)
        CFG_SPLIT_MODE: mode = data[1:0];
        CFG_DELIM_CNT:  count = data[2:0];
        CFG_DELIM_LENS: lens = data[15:0];
        CFG_DELIM_A:    custom[0] = data;
        CFG_DELIM_B:    custom[1] = data;
        CFG_DELIM_C:    custom[2] = data;
        CFG_DELIM_D:    custom[3] = data;
        default: ;
      endcase
    endfunction

    function int unsigned live_delims();
      int unsigned n;
      if (mode == MODE_LINE || mode == MODE_DOUBLE) return NUM_SLOTS;
      n = count;
      if (n > MAX_DELIMS) n = MAX_DELIMS;
      if (n > NUM_SLOTS) n = NUM_SLOTS;
      return n;
    endfunction

    // Delimiter in priority slot i under the current mode
    function void delim_at(int unsigned i, output logic [3:0] len, output logic [63:0] val);
      if (mode == MODE_LINE) begin
        case (i % 4)
          0:       begin len = 4'd2; val = 64'({CHAR_CR, CHAR_LF}); end
          1:       begin len = 4'd1; val = 64'(CHAR_LF); end
          2:       begin len = 4'd2; val = 64'({CHAR_LF, CHAR_CR}); end
          default: begin len = 4'd1; val = 64'(CHAR_CR); end
        endcase
      end else if (mode == MODE_DOUBLE) begin
        case (i % 4)
          0:       begin len = 4'd2; val = 64'({CHAR_LF, CHAR_LF}); end
          1:       begin len = 4'd4; val = 64'({CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF}); end
          2:       begin len = 4'd2; val = 64'({CHAR_CR, CHAR_CR}); end
          default: begin len = 4'd4; val = 64'({CHAR_LF, CHAR_CR, CHAR_LF, CHAR_CR}); end
        endcase
      end else begin
        len = lens[4*(i%4) +: 4];
        val = custom[i%4];
      end
    endfunction

    function void push_piece(logic [7:0] b, kind_e k, logic f);
      pds_result_t p;
      p.out_byte   = b;
      p.kind       = k;
      p.final_item = f;
      expected_pieces.push_back(p);
    endfunction

    function void drop_bytes(int unsigned n);
      if (n > fill) n = fill;
      for (int unsigned j = 0; j + n < fill; j++) window[j] = window[j+n];
      fill = fill - n;
    endfunction

    // Decide the byte at the window head: first matching delimiter wins
    function void decide_head();
      int unsigned n;
      logic [3:0]  len;
      logic [63:0] val;
      bit          hit;
      n = live_delims();
      for (int unsigned i = 0; i < n; i++) begin
        delim_at(i, len, val);
        if (len == 0 || len > MAX_DELIM_BYTES || len > fill) continue;
        hit = 1;
        for (int unsigned j = 0; j < len; j++)
          if (val[8*j +: 8] != window[j]) hit = 0;
        if (hit) begin
          push_piece(8'h00, has_bytes ? KIND_END : KIND_NULL, 1'b0);
          has_bytes = 0;
          drop_bytes(len);
          return;
        end
      end
      push_piece(window[0], KIND_BYTE, 1'b0);
      has_bytes = 1;
      drop_bytes(1);
    endfunction

    function void take_request(pds_item_t it);
      int unsigned k;
      k = 0;
      if (it.byte_present && fill < MAX_DELIM_BYTES) begin
        window[fill] = it.in_byte;
        fill++;
      end
      if (it.end_of_string) begin
        while (fill > 0 && k < MAX_DELIM_BYTES) begin
          decide_head();
          k++;
        end
        push_piece(8'h00, has_bytes ? KIND_END : KIND_NULL, 1'b1);
        fill      = 0;
        has_bytes = 0;
      end else if (fill >= MAX_DELIM_BYTES) begin
        decide_head();
      end
    endfunction

    function void match_piece(logic [7:0] b, logic [1:0] k, logic f);
      pds_result_t want;
      if (expected_pieces.size() == 0) begin
        $error("unexpected piece: out_byte=%0h kind=%0d final_item=%0b", b, k, f);
        errors++;
        return;
      end
      want = expected_pieces.pop_front();
      if (b !== want.out_byte) begin
        $error("out_byte: expected %0h, got %0h", want.out_byte, b);
        errors++;
      end
      if (k !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, k);
        errors++;
      end
      if (f !== want.final_item) begin
        $error("final_item: expected %0b, got %0b", want.final_item, f);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return expected_pieces.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  pds_in_if  in_if ();
  pds_out_if out_if ();

  prioritized_delimiter_splitter_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  split_tracker tracker;
  int unsigned  in_idle_pct;
  int unsigned  out_idle_pct;
  int unsigned  requests_sent;
  pds_item_t    text_q [$];
  logic [3:0]   stim_len [NUM_SLOTS];
  logic [63:0]  stim_val [NUM_SLOTS];

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Result side: random backpressure, check every accepted piece
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      tracker.match_piece(out_if.out_byte, out_if.kind, out_if.final_item);
    out_if.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Copy of the active delimiters, used to steer random text toward matches
  function automatic void load_stim_delims();
    for (int unsigned i = 0; i < NUM_SLOTS; i++) tracker.delim_at(i, stim_len[i], stim_val[i]);
  endfunction

  function automatic logic [7:0] small_byte();
    case ($urandom_range(5))
      0:       return "a";
      1:       return "b";
      2:       return 8'h00;
      3:       return 8'hFF;
      4:       return CHAR_LF;
      default: return CHAR_CR;
    endcase
  endfunction

  function automatic logic [63:0] random_delim();
    logic [63:0] v;
    if ($urandom_range(4) == 0) return {$urandom, $urandom};
    for (int unsigned j = 0; j < 8; j++) v[8*j +: 8] = small_byte();
    return v;
  endfunction

  function automatic void push_byte(logic [7:0] b);
    pds_item_t it;
    it.in_byte       = b;
    it.byte_present  = 1'b1;
    it.end_of_string = 1'b0;
    text_q.push_back(it);
  endfunction

  // Close the string, on the last byte or on a request that carries no byte
  function automatic void end_text(bit on_last_byte);
    pds_item_t it;
    if (on_last_byte && text_q.size() != 0) begin
      text_q[text_q.size()-1].end_of_string = 1'b1;
    end else begin
      it.in_byte       = 8'($urandom);
      it.byte_present  = 1'b0;
      it.end_of_string = 1'b1;
      text_q.push_back(it);
    end
  endfunction

  // Random text: whole delimiters, cut-off delimiters and filler bytes
  function automatic void build_random_text();
    int unsigned target, slot, n, r;
    text_q.delete();
    target = ($urandom_range(9) == 0) ? $urandom_range(30, 9) : $urandom_range(10);
    while (text_q.size() < target) begin
      r    = $urandom_range(99);
      slot = $urandom_range(NUM_SLOTS - 1);
      n    = (stim_len[slot] > MAX_DELIM_BYTES) ? MAX_DELIM_BYTES : stim_len[slot];
      if (r < 40) begin
        for (int unsigned j = 0; j < n; j++) push_byte(stim_val[slot][8*j +: 8]);
      end else if (r < 55) begin
        n = $urandom_range(n);
        for (int unsigned j = 0; j < n; j++) push_byte(stim_val[slot][8*j +: 8]);
      end else begin
        push_byte(($urandom_range(3) == 0) ? 8'($urandom) : small_byte());
      end
    end
    end_text($urandom_range(99) >= 15);
  endfunction

  task automatic send_request(pds_item_t it);
    while ($urandom_range(99) < in_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid         <= 1'b1;
    in_if.in_byte       <= it.in_byte;
    in_if.byte_present  <= it.byte_present;
    in_if.end_of_string <= it.end_of_string;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    tracker.take_request(it);
  endtask

  // Hold off new requests until every expected piece has come out
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_text();
    pds_item_t noise;
    foreach (text_q[i]) begin
      if ($urandom_range(99) < 6) begin
        noise.in_byte       = 8'($urandom);
        noise.byte_present  = 1'b0;
        noise.end_of_string = 1'b0;
        send_request(noise);
      end
      if ($urandom_range(99) < 2) wait_drained();
      send_request(text_q[i]);
      requests_sent++;
    end
  endtask

  task automatic write_reg(cfg_index_e idx, logic [63:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    tracker.write_reg(idx, data);
  endtask

  // Registers change only with the block idle and the string closed
  task automatic apply_settings(logic [1:0] mode, logic [2:0] cnt, logic [15:0] lens,
                                logic [63:0] va, logic [63:0] vb, logic [63:0] vc,
                                logic [63:0] vd);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(CFG_SPLIT_MODE, 64'(mode));
    write_reg(CFG_DELIM_CNT, 64'(cnt));
    write_reg(CFG_DELIM_LENS, 64'(lens));
    write_reg(CFG_DELIM_A, va);
    write_reg(CFG_DELIM_B, vb);
    write_reg(CFG_DELIM_C, vc);
    write_reg(CFG_DELIM_D, vd);
    cfg_we_i <= 1'b0;
    load_stim_delims();
  endtask

  initial begin
    logic [1:0]  mode;
    logic [2:0]  cnt;
    logic [15:0] lens;
    logic [63:0] va, vb, vc, vd;
    int unsigned sent_before;
    pds_item_t   noise;

    tracker             = new();
    in_idle_pct         = 38;
    out_idle_pct        = 85;
    requests_sent       = 0;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_index_i         = CFG_SPLIT_MODE;
    cfg_data_i          = '0;
    in_if.valid         = 1'b0;
    in_if.in_byte       = '0;
    in_if.byte_present  = 1'b0;
    in_if.end_of_string = 1'b0;
    out_if.ready        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    load_stim_delims();

    // Line breaks from reset: empty string, lone LF, priority of LF CR over LF
    text_q.delete();
    end_text(0);
    run_text();
    text_q.delete();
    push_byte(CHAR_LF);
    end_text(1);
    run_text();
    text_q.delete();
    push_byte("a");
    push_byte(CHAR_LF);
    push_byte(CHAR_CR);
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    push_byte(8'h00);
    push_byte(8'hFF);
    end_text(1);
    run_text();
    // Request without a byte is ignored; string end without a byte drains the window
    noise.in_byte       = 8'hA5;
    noise.byte_present  = 1'b0;
    noise.end_of_string = 1'b0;
    send_request(noise);
    text_q.delete();
    push_byte(CHAR_CR);
    end_text(0);
    run_text();

    // Blank-line breaks: a four-byte delimiter cut off by the string end
    apply_settings(MODE_DOUBLE, 3'd1, 16'h0000, '0, '0, '0, '0);
    text_q.delete();
    push_byte(CHAR_LF);
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    end_text(1);
    run_text();
    text_q.delete();
    push_byte(CHAR_LF);
    push_byte(CHAR_LF);
    push_byte(CHAR_CR);
    push_byte(CHAR_CR);
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    push_byte(CHAR_CR);
    push_byte(CHAR_LF);
    end_text(1);
    run_text();

    // Mode three as custom, count capped, zero and oversized lengths disabled
    apply_settings(MODE_ALIAS_CUST, 3'd7, 16'hF013, 64'h7A7978, 64'h78, 64'h78,
                   {8{8'h78}});
    text_q.delete();
    push_byte("x");
    push_byte("y");
    push_byte("x");
    push_byte("y");
    push_byte("z");
    push_byte("x");
    end_text(1);
    run_text();

    // Random text over a series of delimiter settings
    for (int s = 0; s < 9; s++) begin
      case (s / 3)
        0:       begin in_idle_pct = 38; out_idle_pct = 85; end
        1:       begin in_idle_pct = 85; out_idle_pct = 38; end
        default: begin in_idle_pct = 0;  out_idle_pct = 0;  end
      endcase
      mode = MODE_CUSTOM;
      cnt  = 3'd4;
      for (int unsigned j = 0; j < NUM_SLOTS; j++) lens[4*j +: 4] = 4'($urandom_range(8, 1));
      va = random_delim();
      vb = random_delim();
      vc = random_delim();
      vd = random_delim();
      case (s)
        0: begin mode = MODE_LINE; cnt = 3'($urandom); lens = 16'($urandom); end
        1: begin mode = MODE_DOUBLE; cnt = 3'($urandom); lens = 16'($urandom); end
        3: begin cnt = 3'd7; lens = {4'd15, 4'd0, lens[7:0]}; end
        4: begin mode = MODE_ALIAS_CUST; cnt = 3'($urandom_range(4, 1)); end
        5: begin cnt = 3'd0; lens = 16'hFFFF; end
        6: begin lens = 16'h8888; va = '1; vb = '0; end
        7: begin cnt = 3'd1; lens = 16'h0001; end
        8: begin mode = 2'($urandom); cnt = 3'($urandom); lens = 16'($urandom); end
        default: ;
      endcase
      apply_settings(mode, cnt, lens, va, vb, vc, vd);
      sent_before = requests_sent;
      while (requests_sent - sent_before < SETTING_ITEMS) begin
        build_random_text();
        run_text();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
